FILE: design/core_affinity_assigner_macros.svh
// Assertion helpers; expect i_clk and i_rst_n in the calling scope.
`ifndef CORE_AFFINITY_ASSIGNER_MACROS_SVH
`define CORE_AFFINITY_ASSIGNER_MACROS_SVH

`define CAA_CHECK(lbl, prop) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    (prop)) else $error("caa check failed");

`define CAA_IMPLY(lbl, a, c) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    (a) |-> (c)) else $error("caa implication failed");

`define CAA_NEXT(lbl, a, c) lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
    (a) |=> (c)) else $error("caa next-cycle check failed");

`endif

FILE: design/caa_pkg.sv
`default_nettype none
package caa_pkg;
    localparam int MAX_CORES       = 16;
    localparam int TABLE_ENTRIES   = 16;
    localparam int CORES_PER_ENTRY = 16;
    localparam int SAMPLE_WIDTH    = 48;
    localparam int RESULT_LIMIT    = 16;

    localparam int IN_W  = 128;
    localparam int OUT_W = 16;

    localparam logic [4:0] ACTIVE_RESET = 5'd16;
    localparam logic       OP_LOAD      = 1'b0;
    localparam logic       OP_REQ       = 1'b1;

    typedef struct packed {
        logic load;
        logic capture;
        logic out_none;
        logic srch_rd;
        logic srch_next;
        logic hit_set;
        logic core_rd;
        logic out_hit;
        logic alloc;
        logic rr_sub;
        logic rr_emit;
        logic sel_init;
        logic sel_step;
        logic sel_emit;
    } t_cmd;

    typedef struct packed {
        logic in_op;
        logic in_zero;
        logic hit;
        logic srch_end;
        logic any_valid;
        logic rr_ge;
        logic scan_end;
        logic out_last;
    } t_status;
endpackage
`default_nettype wire

FILE: design/core_affinity_assigner.sv
// Core affinity assigner. Slave items with tuser 0 store one core's load sample
// and finish with no result; items with tuser 1 ask cores for a (database,
// role) pair and produce 1 to 16 result items, tlast on the final one.
// A request scans the table one entry at a time, a read state then a compare
// state per entry, through all TABLE_ENTRIES entries on a miss. A hit then
// emits each stored core id in turn, waiting on the output handshake. A miss
// with no valid sample emits cores in round-robin order after up to MAX_CORES-1
// reduction steps of the round-robin pointer; a miss with valid samples runs one
// selection pass per result. Only one item is in work at a time; the slave side
// is ready only when the block is idle. The core id table starts undefined;
// entries are read only after they were written, so no clearing pass is needed.
`default_nettype none
module core_affinity_assigner #(
    parameter int MAX_CORES       = caa_pkg::MAX_CORES,
    parameter int TABLE_ENTRIES   = caa_pkg::TABLE_ENTRIES,
    parameter int CORES_PER_ENTRY = caa_pkg::CORES_PER_ENTRY,
    parameter int SAMPLE_WIDTH    = caa_pkg::SAMPLE_WIDTH
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire  [4:0]                 i_cfg_wdata,   // active_cores
    input  wire                        s_axis_tvalid,
    output logic                       s_axis_tready,
    // core_index[3:0] sample_valid[4] cycle_count[52:5] database_id[84:53]
    // role_id[116:85] req_count[121:117], zero above
    input  wire  [caa_pkg::IN_W-1:0]   s_axis_tdata,
    input  wire                        s_axis_tuser,  // op
    output logic                       m_axis_tvalid,
    input  wire                        m_axis_tready,
    output logic [caa_pkg::OUT_W-1:0]  m_axis_tdata,  // core_id[3:0] core_count[8:4]
    output logic [1:0]                 m_axis_tuser,  // reused[0] none_assigned[1]
    output logic                       m_axis_tlast
);
    caa_pkg::t_cmd    w_cmd;
    caa_pkg::t_status w_status;

    caa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    caa_dp #(
        .MAX_CORES       (MAX_CORES),
        .TABLE_ENTRIES   (TABLE_ENTRIES),
        .CORES_PER_ENTRY (CORES_PER_ENTRY),
        .SAMPLE_WIDTH    (SAMPLE_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_tdata     (s_axis_tdata),
        .i_tuser     (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_tdata     (m_axis_tdata),
        .o_tuser     (m_axis_tuser),
        .o_tlast     (m_axis_tlast)
    );
endmodule
`default_nettype wire

FILE: design/caa_dp.sv
`default_nettype none
module caa_dp #(
    parameter int MAX_CORES       = caa_pkg::MAX_CORES,
    parameter int TABLE_ENTRIES   = caa_pkg::TABLE_ENTRIES,
    parameter int CORES_PER_ENTRY = caa_pkg::CORES_PER_ENTRY,
    parameter int SAMPLE_WIDTH    = caa_pkg::SAMPLE_WIDTH
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_we,
    input  wire  [4:0]                 i_cfg_wdata,
    input  wire  [caa_pkg::IN_W-1:0]   i_tdata,
    input  wire                        i_tuser,
    input  caa_pkg::t_cmd              i_cmd,
    output caa_pkg::t_status           o_status,
    output logic [caa_pkg::OUT_W-1:0]  o_tdata,
    output logic [1:0]                 o_tuser,
    output logic                       o_tlast
);
    localparam int CW = $clog2(MAX_CORES);
    localparam int TW = $clog2(MAX_CORES + 1);
    localparam int EW = $clog2(TABLE_ENTRIES);
    localparam int FW = $clog2(TABLE_ENTRIES + 1);
    localparam int AW = $clog2(TABLE_ENTRIES * CORES_PER_ENTRY);
    localparam int NE = TABLE_ENTRIES * CORES_PER_ENTRY;

    // input unpack
    logic [3:0]  w_ci;
    logic        w_sv;
    logic [47:0] w_cc;
    logic [31:0] w_db, w_role;
    logic [4:0]  w_rq;
    assign w_ci   = i_tdata[3:0];
    assign w_sv   = i_tdata[4];
    assign w_cc   = i_tdata[52:5];
    assign w_db   = i_tdata[84:53];
    assign w_role = i_tdata[116:85];
    assign w_rq   = i_tdata[121:117];

    logic [4:0] r_active;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= caa_pkg::ACTIVE_RESET;
        end else if (i_cfg_we) begin
            r_active <= i_cfg_wdata;
        end
    end

    // core load samples
    logic [SAMPLE_WIDTH-1:0] r_sample [MAX_CORES];
    logic [MAX_CORES-1:0]    r_ok;

    // assignment table
    logic [31:0]  r_mdb   [TABLE_ENTRIES];
    logic [31:0]  r_mrole [TABLE_ENTRIES];
    logic [4:0]   r_mcnt  [TABLE_ENTRIES];
    logic [CW-1:0] r_mcore [NE];
    logic [FW-1:0] r_fill;
    logic [EW-1:0] r_head;

    logic [31:0]  r_db, r_role;
    logic [4:0]   r_req, r_n, r_k;
    logic [TW-1:0] r_total, r_j;
    logic [EW-1:0] r_s, r_phys, r_wslot;
    logic         r_any;
    logic [31:0]  r_rd_db, r_rd_role;
    logic [4:0]   r_rd_cnt;
    logic         r_rd_vld;
    logic [CW-1:0] r_core_rd;
    logic [CW-1:0] r_rr, r_cur, r_m;
    logic [CW-1:0] r_order [MAX_CORES];
    logic         r_best_ok;
    logic [SAMPLE_WIDTH-1:0] r_best_val;

    logic [3:0] r_o_core;
    logic [4:0] r_o_cnt;
    logic       r_o_reused, r_o_none, r_o_last;

    logic [TW-1:0] w_total;
    logic [4:0]    w_req;
    logic          w_any;
    logic [EW-1:0] w_slot;
    logic          w_full;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic [CW-1:0] w_jc, w_i, w_om, w_nxt;
    logic [4:0]    w_hit_n;

    always_comb begin
        if (r_active == 5'd0) begin
            w_total = TW'(1);
        end else if (32'(r_active) > MAX_CORES) begin
            w_total = TW'(MAX_CORES);
        end else begin
            w_total = TW'(r_active);
        end
        w_req = w_rq;
        if (32'(w_req) > 32'(w_total)) w_req = 5'(w_total);
        if (32'(w_req) > CORES_PER_ENTRY) w_req = 5'(CORES_PER_ENTRY);
        if (32'(w_req) > caa_pkg::RESULT_LIMIT) w_req = 5'(caa_pkg::RESULT_LIMIT);
        w_any = 1'b0;
        for (int c = 0; c < MAX_CORES; c++) begin
            if (c < 32'(w_total) && r_ok[c]) w_any = 1'b1;
        end
    end

    assign w_full    = (r_fill == FW'(TABLE_ENTRIES));
    assign w_slot    = w_full ? r_head : r_fill[EW-1:0];
    assign w_rd_addr = AW'(r_phys) * AW'(CORES_PER_ENTRY) + AW'(r_k);
    assign w_wr_addr = AW'(r_wslot) * AW'(CORES_PER_ENTRY) + AW'(r_k);
    assign w_jc      = r_order[r_j[CW-1:0]];
    assign w_i       = CW'(r_k);
    assign w_om      = r_order[r_m];
    assign w_nxt     = (32'(r_cur) + 1 == 32'(r_total)) ? '0 : CW'(r_cur + 1'b1);
    assign w_hit_n   = (r_rd_cnt > r_req) ? r_req : r_rd_cnt;

    // control-side state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ok   <= '0;
            r_fill <= '0;
            r_head <= '0;
            r_rr   <= '0;
        end else begin
            if (i_cmd.load && 32'(w_ci) < MAX_CORES) begin
                r_ok[CW'(w_ci)] <= w_sv;
            end
            if (i_cmd.alloc) begin
                if (w_full) begin
                    r_head <= (32'(r_head) == TABLE_ENTRIES - 1) ? '0 : EW'(r_head + 1'b1);
                end else begin
                    r_fill <= FW'(r_fill + 1'b1);
                end
            end
            if (i_cmd.rr_emit) r_rr <= w_nxt;
        end
    end

    // payload and memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load && 32'(w_ci) < MAX_CORES) begin
            r_sample[CW'(w_ci)] <= SAMPLE_WIDTH'(w_cc);
        end
        if (i_cmd.capture) begin
            r_db    <= w_db;
            r_role  <= w_role;
            r_req   <= w_req;
            r_total <= w_total;
            r_s     <= '0;
            r_any   <= w_any;
            r_cur   <= r_rr;
            for (int c = 0; c < MAX_CORES; c++) r_order[c] <= CW'(c);
        end
        if (i_cmd.srch_rd) begin
            r_rd_db   <= r_mdb[r_s];
            r_rd_role <= r_mrole[r_s];
            r_rd_cnt  <= r_mcnt[r_s];
            r_rd_vld  <= (FW'(r_s) < r_fill);
        end
        if (i_cmd.srch_next) r_s <= EW'(r_s + 1'b1);
        if (i_cmd.hit_set) begin
            r_n    <= w_hit_n;
            r_phys <= r_s;
            r_k    <= '0;
        end
        if (i_cmd.core_rd) r_core_rd <= r_mcore[w_rd_addr];
        if (i_cmd.alloc) begin
            r_wslot        <= w_slot;
            r_mdb[w_slot]  <= r_db;
            r_mrole[w_slot] <= r_role;
            r_mcnt[w_slot] <= r_req;
            r_n            <= r_req;
            r_k            <= '0;
        end
        if (i_cmd.rr_sub) r_cur <= CW'(r_cur - CW'(r_total));
        if (i_cmd.sel_init) begin
            r_m        <= w_i;
            r_best_ok  <= r_ok[r_order[w_i]];
            r_best_val <= r_sample[r_order[w_i]];
            r_j        <= TW'(r_k) + 1'b1;
        end
        if (i_cmd.sel_step) begin
            if (r_ok[w_jc] && (!r_best_ok || r_sample[w_jc] < r_best_val)) begin
                r_m        <= r_j[CW-1:0];
                r_best_ok  <= 1'b1;
                r_best_val <= r_sample[w_jc];
            end
            r_j <= TW'(r_j + 1'b1);
        end
        if (i_cmd.sel_emit && r_m != w_i) begin
            r_order[w_i] <= w_om;
            r_order[r_m] <= r_order[w_i];
        end

        // output register, one item per emit command
        if (i_cmd.out_none) begin
            r_o_core   <= '0;
            r_o_cnt    <= '0;
            r_o_reused <= 1'b0;
            r_o_none   <= 1'b1;
            r_o_last   <= 1'b1;
        end
        if (i_cmd.out_hit || i_cmd.rr_emit || i_cmd.sel_emit) begin
            r_o_cnt    <= r_n;
            r_o_reused <= i_cmd.out_hit;
            r_o_none   <= 1'b0;
            r_o_last   <= (5'(r_k + 1'b1) == r_n);
            r_k        <= 5'(r_k + 1'b1);
        end
        if (i_cmd.out_hit) r_o_core <= 4'(r_core_rd);
        if (i_cmd.rr_emit) begin
            r_o_core           <= 4'(r_cur);
            r_mcore[w_wr_addr] <= r_cur;
            r_cur              <= w_nxt;
        end
        if (i_cmd.sel_emit) begin
            r_o_core           <= 4'(w_om);
            r_mcore[w_wr_addr] <= w_om;
        end
    end

    always_comb begin
        o_status.in_op     = i_tuser;
        o_status.in_zero   = (w_req == 5'd0) || (w_db == 32'd0);
        o_status.hit       = r_rd_vld && (r_rd_db == r_db) && (r_rd_role == r_role);
        o_status.srch_end  = (32'(r_s) == TABLE_ENTRIES - 1);
        o_status.any_valid = r_any;
        o_status.rr_ge     = (32'(r_cur) >= 32'(r_total));
        o_status.scan_end  = (r_j >= r_total);
        o_status.out_last  = r_o_last;
    end

    assign o_tdata = {7'd0, r_o_cnt, r_o_core};
    assign o_tuser = {r_o_none, r_o_reused};
    assign o_tlast = r_o_last;

`include "core_affinity_assigner_macros.svh"
    `CAA_CHECK(a_fill_bound, r_fill <= FW'(TABLE_ENTRIES))
    `CAA_IMPLY(a_head_when_full, r_head != '0, w_full)
    `CAA_NEXT(a_alloc_fill, i_cmd.alloc && !w_full, r_fill == FW'($past(r_fill) + 1'b1))
endmodule
`default_nettype wire

FILE: design/caa_ctrl.sv
`default_nettype none
module caa_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  caa_pkg::t_status  i_status,
    output caa_pkg::t_cmd     o_cmd
);
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRCH_RD  = 4'd1;
    localparam logic [3:0] S_SRCH_CMP = 4'd2;
    localparam logic [3:0] S_HIT_RD   = 4'd3;
    localparam logic [3:0] S_HIT_LD   = 4'd4;
    localparam logic [3:0] S_OUT_HIT  = 4'd5;
    localparam logic [3:0] S_ALLOC    = 4'd6;
    localparam logic [3:0] S_RR_MOD   = 4'd7;
    localparam logic [3:0] S_RR_EMIT  = 4'd8;
    localparam logic [3:0] S_OUT_RR   = 4'd9;
    localparam logic [3:0] S_SEL_INIT = 4'd10;
    localparam logic [3:0] S_SEL_SCAN = 4'd11;
    localparam logic [3:0] S_SEL_EMIT = 4'd12;
    localparam logic [3:0] S_OUT_SEL  = 4'd13;
    localparam logic [3:0] S_OUT_ONE  = 4'd14;

    logic [3:0] r_state, n_state;
    logic       w_take;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT_HIT) || (r_state == S_OUT_RR) ||
                         (r_state == S_OUT_SEL) || (r_state == S_OUT_ONE);
    assign w_take      = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_status.in_op == caa_pkg::OP_LOAD) begin
                        o_cmd.load = 1'b1;
                    end else begin
                        o_cmd.capture = 1'b1;
                        if (i_status.in_zero) begin
                            o_cmd.out_none = 1'b1;
                            n_state = S_OUT_ONE;
                        end else begin
                            n_state = S_SRCH_RD;
                        end
                    end
                end
            end
            S_SRCH_RD: begin
                o_cmd.srch_rd = 1'b1;
                n_state = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (i_status.hit) begin
                    o_cmd.hit_set = 1'b1;
                    n_state = S_HIT_RD;
                end else if (i_status.srch_end) begin
                    n_state = S_ALLOC;
                end else begin
                    o_cmd.srch_next = 1'b1;
                    n_state = S_SRCH_RD;
                end
            end
            S_HIT_RD: begin
                o_cmd.core_rd = 1'b1;
                n_state = S_HIT_LD;
            end
            S_HIT_LD: begin
                o_cmd.out_hit = 1'b1;
                n_state = S_OUT_HIT;
            end
            S_OUT_HIT: begin
                if (w_take) n_state = i_status.out_last ? S_IDLE : S_HIT_RD;
            end
            S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                n_state = i_status.any_valid ? S_SEL_INIT : S_RR_MOD;
            end
            S_RR_MOD: begin
                if (i_status.rr_ge) begin
                    o_cmd.rr_sub = 1'b1;
                end else begin
                    n_state = S_RR_EMIT;
                end
            end
            S_RR_EMIT: begin
                o_cmd.rr_emit = 1'b1;
                n_state = S_OUT_RR;
            end
            S_OUT_RR: begin
                if (w_take) n_state = i_status.out_last ? S_IDLE : S_RR_EMIT;
            end
            S_SEL_INIT: begin
                o_cmd.sel_init = 1'b1;
                n_state = S_SEL_SCAN;
            end
            S_SEL_SCAN: begin
                if (i_status.scan_end) begin
                    n_state = S_SEL_EMIT;
                end else begin
                    o_cmd.sel_step = 1'b1;
                end
            end
            S_SEL_EMIT: begin
                o_cmd.sel_emit = 1'b1;
                n_state = S_OUT_SEL;
            end
            S_OUT_SEL: begin
                if (w_take) n_state = i_status.out_last ? S_IDLE : S_SEL_INIT;
            end
            S_OUT_ONE: begin
                if (w_take) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`include "core_affinity_assigner_macros.svh"
    `CAA_CHECK(a_one_side, !(o_in_ready && o_out_valid))
    `CAA_NEXT(a_none_is_last, r_state == S_IDLE && n_state == S_OUT_ONE, i_status.out_last)
    `CAA_IMPLY(a_cmd_onehot_emit, 1'b1,
        $onehot0({o_cmd.out_hit, o_cmd.rr_emit, o_cmd.sel_emit, o_cmd.out_none}))
endmodule
`default_nettype wire
